// ----- sv/fht_pkg.sv -----
// Shared types and status codes for the fragment hole tracker.
package fht_pkg;

    localparam logic [1:0] ST_ACCEPT = 2'd0;
    localparam logic [1:0] ST_IGNORE = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    localparam int WORD_W = 16;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_INIT = 7'b0000010,
        S_SCAN = 7'b0000100,
        S_LAST = 7'b0001000,
        S_UPD  = 7'b0010000,
        S_WR2  = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

endpackage

// ----- sv/fht_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/fragment_hole_tracker.sv -----
// Fragment hole tracker: hole-descriptor list for message reassembly.
//
// Input channel s_*: one beat per fragment (offset, length, message length,
// first and compatible flags). Output channel m_*: one beat per fragment with
// status (accepted / ignored / rejected), completion flag and open hole count.
// m_tvalid rises from the output register once the fragment has passed
// S_DONE. A fragment settled by the length, error or range checks alone
// goes straight to S_DONE (through S_INIT for a first fragment of nonzero
// length). Otherwise S_INIT comes first for a first fragment and the scan
// sets the time: one hole entry is read from the descriptor RAM each cycle,
// then S_LAST covers the last read, S_UPD the update and S_WR2 a second
// write when a hole splits in two. s_tready is high only while the block is
// idle; one fragment is in work at a time.
// The result sits in an output register, so the next fragment is
// taken while a result still waits; a stalled m_tready holds the block in
// its final state, S_DONE, only when a second result is ready behind the first.
// Reset clears the hole valid bits, error, stored length and the output
// valid flag; the descriptor RAM itself is not cleared and needs no sweep.
module fragment_hole_tracker #(
    parameter int MAX_HOLES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // msg_length, frag_offset, frag_len
    input  logic [1:0]  s_tuser,   // first, compatible
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // status, complete, holes_left
);

    localparam int IDX_W = $clog2(MAX_HOLES);
    localparam int CNT_W = $clog2(MAX_HOLES + 1);
    localparam int W     = fht_pkg::WORD_W;

    fht_pkg::state_t state_reg, state_next;

    logic [MAX_HOLES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [W-1:0]         len_reg, len_next;
    logic                 err_reg, err_next;
    logic                 asm_reg, asm_next;
    logic [W-1:0]         off_reg, off_next;
    logic [W-1:0]         back_reg, back_next;
    logic                 bad_reg, bad_next;
    logic [1:0]           status_reg, status_next;

    logic [IDX_W-1:0]     scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]     data_idx_reg;
    logic                 data_vld_reg;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     m_idx_reg, m_idx_next;
    logic [W-1:0]         m_start_reg, m_start_next;
    logic [W-1:0]         m_end_reg, m_end_next;
    logic                 have0_reg, have0_next;
    logic                 have1_reg, have1_next;
    logic [IDX_W-1:0]     f0_reg, f0_next;
    logic [IDX_W-1:0]     f1_reg, f1_next;

    logic [IDX_W-1:0]     wr2_addr_reg, wr2_addr_next;
    logic [2*W-1:0]       wr2_data_reg, wr2_data_next;

    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_data_reg, out_data_next;

    // RAM ports
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [2*W-1:0]       ram_wdata;
    logic [2*W-1:0]       ram_rdata;

    // input fields
    logic                 in_first, in_compat;
    logic [W-1:0]         in_mlen, in_off, in_len;
    logic [W-1:0]         eff_len;
    logic                 range_bad;

    // scan and update terms
    logic [W-1:0]         rd_start, rd_end;
    logic                 rd_valid, hit;
    logic                 head_gap, after, full;
    logic                 use_f0;
    logic [IDX_W-1:0]     slot_a, slot_b;
    logic [8:0]           cnt_ext;
    logic [4:0]           holes_sat;
    logic                 complete;

    assign in_mlen   = s_tdata[15:0];
    assign in_off    = s_tdata[31:16];
    assign in_len    = s_tdata[47:32];
    assign in_first  = s_tuser[0];
    assign in_compat = s_tuser[1];

    assign eff_len   = in_first ? in_mlen : len_reg;
    assign range_bad = (in_len == '0) ||
                       (({1'b0, in_off} + {1'b0, in_len}) > {1'b0, eff_len});

    assign rd_start = ram_rdata[W-1:0];
    assign rd_end   = ram_rdata[2*W-1:W];
    assign rd_valid = valid_reg[data_idx_reg];
    assign hit      = rd_valid && (rd_start <= off_reg) && (back_reg <= rd_end);

    assign head_gap = m_start_reg < off_reg;
    assign after    = back_reg < m_end_reg;
    assign full     = head_gap && after && (cnt_reg == CNT_W'(MAX_HOLES));

    // the two lowest free slots once the matched hole is released
    assign use_f0 = have0_reg && (f0_reg < m_idx_reg);
    assign slot_a = use_f0 ? f0_reg : m_idx_reg;
    assign slot_b = use_f0 ? ((have1_reg && (f1_reg < m_idx_reg)) ? f1_reg : m_idx_reg)
                           : f0_reg;

    assign cnt_ext   = 9'(cnt_reg);
    assign holes_sat = (cnt_ext > 9'd31) ? 5'd31 : cnt_ext[4:0];
    assign complete  = asm_reg && (cnt_reg == '0) && !err_reg;

    assign s_tready = (state_reg == fht_pkg::S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    fht_ram #(
        .WIDTH(2 * W),
        .DEPTH(MAX_HOLES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        err_next       = err_reg;
        asm_next       = asm_reg;
        off_next       = off_reg;
        back_next      = back_reg;
        bad_next       = bad_reg;
        status_next    = status_reg;
        scan_idx_next  = scan_idx_reg;
        found_next     = found_reg;
        m_idx_next     = m_idx_reg;
        m_start_next   = m_start_reg;
        m_end_next     = m_end_reg;
        have0_next     = have0_reg;
        have1_next     = have1_reg;
        f0_next        = f0_reg;
        f1_next        = f1_reg;
        wr2_addr_next  = wr2_addr_reg;
        wr2_data_next  = wr2_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;

        // scan results, one entry behind the read address
        if (data_vld_reg)
        begin
            if (hit && !found_reg)
            begin
                found_next   = 1'b1;
                m_idx_next   = data_idx_reg;
                m_start_next = rd_start;
                m_end_next   = rd_end;
            end
            if (!rd_valid)
            begin
                if (!have0_reg)
                begin
                    have0_next = 1'b1;
                    f0_next    = data_idx_reg;
                end
                else if (!have1_reg)
                begin
                    have1_next = 1'b1;
                    f1_next    = data_idx_reg;
                end
            end
        end

        case (state_reg)
            fht_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    off_next      = in_off;
                    back_next     = in_off + in_len - W'(1);
                    bad_next      = range_bad;
                    scan_idx_next = '0;
                    found_next    = 1'b0;
                    have0_next    = 1'b0;
                    have1_next    = 1'b0;
                    if (in_first)
                    begin
                        valid_next  = '0;
                        cnt_next    = '0;
                        len_next    = in_mlen;
                        err_next    = 1'b0;
                        asm_next    = 1'b1;
                        status_next = fht_pkg::ST_IGNORE;
                        // empty message is complete at once
                        state_next  = (in_mlen == '0) ? fht_pkg::S_DONE : fht_pkg::S_INIT;
                    end
                    else if (!asm_reg || err_reg)
                    begin
                        status_next = fht_pkg::ST_REJECT;
                        state_next  = fht_pkg::S_DONE;
                    end
                    else if ((in_mlen != len_reg) || !in_compat)
                    begin
                        err_next    = 1'b1;
                        status_next = fht_pkg::ST_REJECT;
                        state_next  = fht_pkg::S_DONE;
                    end
                    else if (range_bad)
                    begin
                        status_next = fht_pkg::ST_IGNORE;
                        state_next  = fht_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = fht_pkg::S_SCAN;
                    end
                end
            end
            fht_pkg::S_INIT:
            begin
                // one hole over the whole message
                ram_we        = 1'b1;
                ram_waddr     = '0;
                ram_wdata     = {len_reg - W'(1), W'(0)};
                valid_next[0] = 1'b1;
                cnt_next      = CNT_W'(1);
                state_next    = bad_reg ? fht_pkg::S_DONE : fht_pkg::S_SCAN;
            end
            fht_pkg::S_SCAN:
            begin
                if (scan_idx_reg == IDX_W'(MAX_HOLES - 1))
                begin
                    state_next = fht_pkg::S_LAST;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            fht_pkg::S_LAST:
            begin
                state_next = fht_pkg::S_UPD;
            end
            fht_pkg::S_UPD:
            begin
                if (!found_reg)
                begin
                    status_next = fht_pkg::ST_IGNORE;
                    state_next  = fht_pkg::S_DONE;
                end
                else if (full)
                begin
                    err_next    = 1'b1;
                    status_next = fht_pkg::ST_REJECT;
                    state_next  = fht_pkg::S_DONE;
                end
                else
                begin
                    status_next           = fht_pkg::ST_ACCEPT;
                    valid_next[m_idx_reg] = 1'b0;
                    cnt_next = cnt_reg - CNT_W'(1) + CNT_W'(head_gap) + CNT_W'(after);
                    if (head_gap || after)
                    begin
                        ram_we             = 1'b1;
                        ram_waddr          = slot_a;
                        valid_next[slot_a] = 1'b1;
                        ram_wdata = head_gap ? {off_reg - W'(1), m_start_reg}
                                             : {m_end_reg, back_reg + W'(1)};
                    end
                    if (head_gap && after)
                    begin
                        valid_next[slot_b] = 1'b1;
                        wr2_addr_next      = slot_b;
                        wr2_data_next      = {m_end_reg, back_reg + W'(1)};
                        state_next         = fht_pkg::S_WR2;
                    end
                    else
                    begin
                        state_next = fht_pkg::S_DONE;
                    end
                end
            end
            fht_pkg::S_WR2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = wr2_addr_reg;
                ram_wdata  = wr2_data_reg;
                state_next = fht_pkg::S_DONE;
            end
            fht_pkg::S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {holes_sat, complete, status_reg};
                    state_next     = fht_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fht_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fht_pkg::S_IDLE;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            len_reg       <= '0;
            err_reg       <= 1'b0;
            asm_reg       <= 1'b0;
            data_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            cnt_reg       <= cnt_next;
            len_reg       <= len_next;
            err_reg       <= err_next;
            asm_reg       <= asm_next;
            data_vld_reg  <= (state_reg == fht_pkg::S_SCAN);
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg      <= off_next;
        back_reg     <= back_next;
        bad_reg      <= bad_next;
        status_reg   <= status_next;
        scan_idx_reg <= scan_idx_next;
        data_idx_reg <= scan_idx_reg;
        found_reg    <= found_next;
        m_idx_reg    <= m_idx_next;
        m_start_reg  <= m_start_next;
        m_end_reg    <= m_end_next;
        have0_reg    <= have0_next;
        have1_reg    <= have1_next;
        f0_reg       <= f0_next;
        f1_reg       <= f1_next;
        wr2_addr_reg <= wr2_addr_next;
        wr2_data_reg <= wr2_data_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ----- sv/fht_checker.sv -----
// Port-level checks for the fragment hole tracker, bound to the top level.
module fht_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one fragment in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after accepting a beat");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] == fht_pkg::ST_ACCEPT) ||
                     (m_tdata[1:0] == fht_pkg::ST_IGNORE) ||
                     (m_tdata[1:0] == fht_pkg::ST_REJECT))
        else $error("undefined status code");

    a_complete_no_holes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> (m_tdata[7:3] == 5'd0))
        else $error("complete with holes still open");

    a_reject_not_complete: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == fht_pkg::ST_REJECT) |-> !m_tdata[2])
        else $error("rejected beat reports completion");

endmodule

bind fragment_hole_tracker fht_checker u_fht_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
